// File: hdl/ranked_insert_queue_macros.svh
// Assertion helpers used by the checker file.
`ifndef RANKED_INSERT_QUEUE_MACROS_SVH
`define RANKED_INSERT_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RIQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define RIQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: hdl/riq_pkg.sv
package riq_pkg;

  // Table geometry
  localparam int DEPTH       = 64;
  localparam int GRADE_BITS  = 16;
  localparam int ID_BITS     = 16;
  localparam int COURSE_BITS = 10;
  localparam int CNT_BITS    = $clog2(DEPTH + 1);
  localparam int LVL         = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Action codes carried on s_tuser
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation the controller issues to the datapath
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INSERT,
    OP_REMOVE,
    OP_REJ_FULL,
    OP_REJ_EMPTY
  } op_t;

  // One table entry: flags bit0 first choice hit, bit1 second choice hit
  typedef struct packed {
    logic [GRADE_BITS-1:0] grade;
    logic [ID_BITS-1:0]    id;
    logic [1:0]            flags;
  } entry_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic is_remove;
    logic empty;
    logic full;
  } sts_t;

endpackage

// File: hdl/riq_ctrl.sv
module riq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  riq_pkg::sts_t sts,
  output riq_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  state_t state;
  logic   can_post;

  // Result slot is free, or its beat leaves this cycle
  assign can_post = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Issue the table operation once the result slot can take it
  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.op   = riq_pkg::OP_IDLE;
    if (state == S_UPD && can_post) begin
      if (sts.is_remove) begin
        cmd.op = sts.empty ? riq_pkg::OP_REJ_EMPTY : riq_pkg::OP_REMOVE;
      end else begin
        cmd.op = sts.full ? riq_pkg::OP_REJ_FULL : riq_pkg::OP_INSERT;
      end
    end
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_UPD;
        end
        S_UPD: begin
          if (can_post) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_UPD && can_post) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/riq_datapath.sv
module riq_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  riq_pkg::cmd_t                     cmd,
  output riq_pkg::sts_t                     sts,
  input  logic                              in_action,
  input  logic [riq_pkg::ID_BITS-1:0]       in_id,
  input  logic [riq_pkg::GRADE_BITS-1:0]    in_grade,
  input  logic [riq_pkg::COURSE_BITS-1:0]   in_first,
  input  logic [riq_pkg::COURSE_BITS-1:0]   in_second,
  input  logic                              cfg_we,
  input  logic [riq_pkg::COURSE_BITS-1:0]   cfg_data,
  output riq_pkg::status_t                  res_status,
  output logic [riq_pkg::GRADE_BITS-1:0]    res_cut,
  output logic [riq_pkg::ID_BITS-1:0]       res_rid,
  output logic [riq_pkg::GRADE_BITS-1:0]    res_rgrade,
  output logic [riq_pkg::CNT_BITS-1:0]      res_count
);

  localparam int D = riq_pkg::DEPTH;
  localparam int L = riq_pkg::LVL;

  logic [riq_pkg::COURSE_BITS-1:0] course;
  logic [riq_pkg::CNT_BITS-1:0]    count;
  logic [riq_pkg::CNT_BITS-1:0]    count_next;
  riq_pkg::entry_t                 slot [D];
  riq_pkg::entry_t                 slot_next [D];
  riq_pkg::entry_t                 item;
  logic                            item_action;
  logic                            in_nf;
  logic                            in_ns;
  logic [D-1:0]                    gb_now;
  logic [D-1:0]                    gb;
  logic [D-1:0]                    pre [L+1];
  logic [riq_pkg::GRADE_BITS-1:0]  cut_next;

  // Does the new item sort ahead of a stored entry
  function automatic logic goes_before(riq_pkg::entry_t e,
                                       logic [riq_pkg::GRADE_BITS-1:0] g,
                                       logic nf, logic ns);
    logic hit;
    hit = 1'b0;
    if (e.grade > g) begin
      hit = 1'b1;
    end else if (e.grade == g) begin
      hit = (nf && e.flags[0]) || (ns && (e.flags[0] || e.flags[1]));
    end
    return hit;
  endfunction

  assign in_nf = (in_first == course);
  assign in_ns = (in_second == course);

  // Compare the incoming item against every occupied cell
  always_comb begin
    for (int i = 0; i < D; i++) begin
      gb_now[i] = (riq_pkg::CNT_BITS'(i) < count) &&
                  goes_before(slot[i], in_grade, in_nf, in_ns);
    end
  end

  // Prefix OR of the hit vector: cell i shifts up when it or some lower cell hit
  always_comb begin
    pre[0] = gb;
    for (int k = 0; k < L; k++) begin
      for (int i = 0; i < D; i++) begin
        pre[k+1][i] = pre[k][i];
        if (i >= (1 << k)) begin
          pre[k+1][i] = pre[k][i] | pre[k][(i >= (1 << k)) ? i - (1 << k) : 0];
        end
      end
    end
  end

  // Next cell contents and result fields
  always_comb begin
    for (int i = 0; i < D; i++) slot_next[i] = slot[i];
    count_next = count;
    cut_next   = (count != '0) ? slot[0].grade : '0;
    unique case (cmd.op)
      riq_pkg::OP_INSERT: begin
        for (int i = 0; i < D; i++) begin
          if (i > 0 && pre[L][(i > 0) ? i - 1 : 0]) begin
            slot_next[i] = slot[(i > 0) ? i - 1 : 0];
          end else if (gb[i] || riq_pkg::CNT_BITS'(i) == count) begin
            slot_next[i] = item;
          end
        end
        count_next = count + 1'b1;
        cut_next   = (gb[0] || count == '0) ? item.grade : slot[0].grade;
      end
      riq_pkg::OP_REMOVE: begin
        for (int i = 0; i < D - 1; i++) slot_next[i] = slot[i+1];
        count_next = count - 1'b1;
        cut_next   = (count > riq_pkg::CNT_BITS'(1)) ? slot[1].grade : '0;
      end
      default: ;
    endcase
  end

  assign sts.is_remove = (item_action == riq_pkg::ACT_REMOVE);
  assign sts.empty     = (count == '0);
  assign sts.full      = (count == riq_pkg::CNT_BITS'(D));

  // Control registers: course and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      course <= '0;
      count  <= '0;
    end else begin
      if (cfg_we) course <= cfg_data;
      count <= count_next;
    end
  end

  // Capture the beat and its compare vector
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_action <= in_action;
      item.grade  <= in_grade;
      item.id     <= in_id;
      item.flags  <= {in_ns, in_nf};
      gb          <= gb_now;
    end
  end

  // Shift the cell row
  always_ff @(posedge clk) begin
    for (int i = 0; i < D; i++) slot[i] <= slot_next[i];
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.op != riq_pkg::OP_IDLE) begin
      res_cut    <= cut_next;
      res_count  <= count_next;
      res_rid    <= '0;
      res_rgrade <= '0;
      unique case (cmd.op)
        riq_pkg::OP_REMOVE: begin
          res_status <= riq_pkg::ST_OK;
          res_rid    <= slot[0].id;
          res_rgrade <= slot[0].grade;
        end
        riq_pkg::OP_REJ_FULL:  res_status <= riq_pkg::ST_FULL;
        riq_pkg::OP_REJ_EMPTY: res_status <= riq_pkg::ST_EMPTY;
        default:               res_status <= riq_pkg::ST_OK;
      endcase
    end
  end

endmodule

// File: hdl/ranked_insert_queue.sv
// Each accepted input beat is captured with its compare vector in the compare step;
// the shift step then updates the 64-cell row and loads the result beat on m_tdata.
// No new beat is taken until the shift is done; a stalled result delays it until m_tready.
// Reset (rst, synchronous): clears the entry count, the course register and
// the result valid; cell contents are not cleared and are read only below count.
module ranked_insert_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // entry_id[15:0], grade[31:16], first_course[41:32],
                                 // second_course[51:42], zero pad
  input  logic        s_tuser,   // action
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,  // current_course
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // status[1:0], cut_score[17:2], removed_id[33:18],
                                 // removed_grade[49:34], entry_count[56:50], zero pad
);

  riq_pkg::cmd_t                 cmd;
  riq_pkg::sts_t                 sts;
  riq_pkg::status_t              res_status;
  logic [riq_pkg::GRADE_BITS-1:0] res_cut;
  logic [riq_pkg::ID_BITS-1:0]    res_rid;
  logic [riq_pkg::GRADE_BITS-1:0] res_rgrade;
  logic [riq_pkg::CNT_BITS-1:0]   res_count;

  assign cfg_ready = 1'b1;

  riq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  riq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_action  (s_tuser),
    .in_id      (s_tdata[15:0]),
    .in_grade   (riq_pkg::GRADE_BITS'(s_tdata[31:16])),
    .in_first   (s_tdata[41:32]),
    .in_second  (s_tdata[51:42]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .res_status (res_status),
    .res_cut    (res_cut),
    .res_rid    (res_rid),
    .res_rgrade (res_rgrade),
    .res_count  (res_count)
  );

  // Pack the result beat
  assign m_tdata = {7'd0,
                    7'(res_count),
                    16'(res_rgrade),
                    16'(res_rid),
                    16'(res_cut),
                    2'(res_status)};

endmodule

// File: hdl/riq_checker.sv
`include "ranked_insert_queue_macros.svh"

module riq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  logic [1:0] r_status;
  logic [6:0] r_count;
  logic       in_beat;
  logic       full_beat;
  logic       empty_beat;
  logic       fields_zero;

  assign r_status    = m_tdata[1:0];
  assign r_count     = m_tdata[56:50];
  assign in_beat     = s_tvalid && s_tready;
  assign full_beat   = m_tvalid && (r_status == 2'(riq_pkg::ST_FULL));
  assign empty_beat  = m_tvalid && (r_status == 2'(riq_pkg::ST_EMPTY));
  assign fields_zero = (r_count == 7'd0) && (m_tdata[49:2] == 48'd0);

  // A stalled result beat holds
  `RIQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Count never exceeds the table depth
  `RIQ_ASSERT_NOW(a_count_range, m_tvalid, r_count <= 7'(riq_pkg::DEPTH))

  // Full reject only at full table; empty reject only at empty table with zero fields
  `RIQ_ASSERT_NOW(a_full_reject, full_beat, r_count == 7'(riq_pkg::DEPTH))
  `RIQ_ASSERT_NOW(a_empty_reject, empty_beat, fields_zero)

  // An input beat is not taken in the cycle right after another
  `RIQ_ASSERT_NEXT(a_spacing, in_beat, !in_beat)

endmodule

bind ranked_insert_queue riq_checker u_riq_checker (.*);

// File: dv/ranked_insert_queue_tb.sv
module ranked_insert_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 3000;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 120;
  localparam int PHASE_COUNT  = 10;
  localparam int REPORT_LIMIT = 10;

  // One request as it travels: action on tuser, the rest on tdata (id lowest)
  typedef struct packed {
    logic                            action;
    logic [3:0]                      pad;
    logic [riq_pkg::COURSE_BITS-1:0] second_course;
    logic [riq_pkg::COURSE_BITS-1:0] first_course;
    logic [riq_pkg::GRADE_BITS-1:0]  grade;
    logic [riq_pkg::ID_BITS-1:0]     entry_id;
  } rank_req_t;

  // One result beat as packed on m_tdata (status lowest)
  typedef struct packed {
    logic [6:0]                     pad;
    logic [riq_pkg::CNT_BITS-1:0]   entry_count;
    logic [riq_pkg::GRADE_BITS-1:0] removed_grade;
    logic [riq_pkg::ID_BITS-1:0]    removed_id;
    logic [riq_pkg::GRADE_BITS-1:0] cut_score;
    riq_pkg::status_t               status;
  } rank_result_t;

  // Sorted table predictor and store of expected results
  class ranked_table_model;
    logic [riq_pkg::GRADE_BITS-1:0]  grades[riq_pkg::DEPTH];
    logic [riq_pkg::ID_BITS-1:0]     ids[riq_pkg::DEPTH];
    logic [1:0]                      hit_flags[riq_pkg::DEPTH];
    int unsigned                     fill;
    logic [riq_pkg::COURSE_BITS-1:0] course;
    rank_result_t                    pending_results[$];
    int unsigned                     mismatch_count;

    function new();
      fill = 0;
      course = '0;
      mismatch_count = 0;
    endfunction

    function void set_course(logic [riq_pkg::COURSE_BITS-1:0] value);
      course = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // New entry ranks ahead of stored slot: higher stored grade, or tie rule
    function bit ranks_ahead(int slot, logic [riq_pkg::GRADE_BITS-1:0] g, bit nf, bit ns);
      if (grades[slot] > g) return 1;
      if (grades[slot] == g) begin
        if (nf && hit_flags[slot][0]) return 1;
        if (ns && (hit_flags[slot][0] || hit_flags[slot][1])) return 1;
      end
      return 0;
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void accept_request(rank_req_t req);
      rank_result_t res;
      bit nf;
      bit ns;
      int pos;
      res = '0;
      res.status = riq_pkg::ST_OK;
      if (req.action == riq_pkg::ACT_INSERT) begin
        if (fill >= riq_pkg::DEPTH) begin
          res.status = riq_pkg::ST_FULL;
        end else begin
          nf = (req.first_course == course);
          ns = (req.second_course == course);
          pos = 0;
          while (pos < fill && !ranks_ahead(pos, req.grade, nf, ns)) pos++;
          for (int i = fill; i > pos; i--) begin
            grades[i] = grades[i-1];
            ids[i] = ids[i-1];
            hit_flags[i] = hit_flags[i-1];
          end
          grades[pos] = req.grade;
          ids[pos] = req.entry_id;
          hit_flags[pos] = {ns, nf};
          fill++;
        end
      end else begin
        if (fill == 0) begin
          res.status = riq_pkg::ST_EMPTY;
        end else begin
          res.removed_id = ids[0];
          res.removed_grade = grades[0];
          for (int i = 1; i < fill; i++) begin
            grades[i-1] = grades[i];
            ids[i-1] = ids[i];
            hit_flags[i-1] = hit_flags[i];
          end
          fill--;
        end
      end
      res.cut_score = (fill > 0) ? grades[0] : '0;
      res.entry_count = riq_pkg::CNT_BITS'(fill);
      pending_results.push_back(res);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(rank_result_t got);
      rank_result_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result beat with nothing expected: st=%0d cut=%h rid=%h rgr=%h cnt=%0d",
                   $realtime, got.status, got.cut_score, got.removed_id,
                   got.removed_grade, got.entry_count);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.cut_score !== want.cut_score ||
          got.removed_id !== want.removed_id || got.removed_grade !== want.removed_grade ||
          got.entry_count !== want.entry_count) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("%0t: result error", $realtime);
          $display("  expected st=%0d cut=%h rid=%h rgr=%h cnt=%0d", want.status,
                   want.cut_score, want.removed_id, want.removed_grade, want.entry_count);
          $display("  actual   st=%0d cut=%h rid=%h rgr=%h cnt=%0d", got.status,
                   got.cut_score, got.removed_id, got.removed_grade, got.entry_count);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // entry_id, grade, first_course, second_course, zero pad
  logic        s_tuser = 1'b0; // action
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_data = '0;  // current_course
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [63:0] m_tdata;        // status, cut_score, removed_id, removed_grade,
                               // entry_count, zero pad

  ranked_table_model table_model = new();
  bit                hold_request = 0;
  int unsigned       idle_cycles = 0;

  ranked_insert_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) table_model.check_result(rank_result_t'(m_tdata));
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst && ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready))) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ranked_insert_queue: mismatch");
        $finish;
      end
    end
  end

  // Receiver: segments of varying stall patterns, plus one long hold on request
  initial begin
    int seg_left;
    int mode;
    int hold_left;
    int tick;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (tick % 4) != 0;
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one request and hold it until accepted
  task automatic drive_item(rank_req_t req);
    s_tvalid <= 1'b1;
    s_tdata <= req[55:0];
    s_tuser <= req.action;
    do @(posedge clk); while (!s_tready);
    table_model.accept_request(req);
  endtask

  // Drop valid and wait out a gap
  task automatic idle_sender(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Write the course register once every expected result has come back
  task automatic write_course(logic [riq_pkg::COURSE_BITS-1:0] value);
    while (table_model.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    table_model.set_course(value);
    cfg_valid <= 1'b0;
  endtask

  function automatic rank_req_t make_req(logic act, logic [15:0] id, logic [15:0] g,
                                         logic [9:0] c1, logic [9:0] c2);
    rank_req_t req;
    req = '0;
    req.action = act;
    req.entry_id = id;
    req.grade = g;
    req.first_course = c1;
    req.second_course = c2;
    return req;
  endfunction

  // Random request: grades crowd onto a few values so ties are common,
  // choices often hit the course or its neighbor
  function automatic rank_req_t random_req(logic [9:0] crs, int insert_pct);
    logic       act;
    logic [15:0] g;
    logic [9:0] c1;
    logic [9:0] c2;
    int         pick;
    act = ($urandom_range(0, 99) < insert_pct) ? riq_pkg::ACT_INSERT : riq_pkg::ACT_REMOVE;
    pick = $urandom_range(0, 9);
    if (pick <= 4) g = 16'(1000 + $urandom_range(0, 3));
    else if (pick <= 7) g = 16'($urandom);
    else if (pick == 8) g = '0;
    else g = '1;
    pick = $urandom_range(0, 9);
    c1 = (pick <= 3) ? crs : (pick <= 5) ? (crs ^ 10'h1) : 10'($urandom);
    pick = $urandom_range(0, 9);
    c2 = (pick <= 3) ? crs : (pick <= 5) ? (crs ^ 10'h1) : 10'($urandom);
    return make_req(act, 16'($urandom), g, c1, c2);
  endfunction

  initial begin
    int insert_pcts[5];
    logic [9:0] crs;
    int burst_left;
    bit no_gaps;
    insert_pcts = '{90, 50, 20, 70, 97};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty remove, extremes, each tie outcome, drain past empty
    write_course(10'd5);
    drive_item(make_req(riq_pkg::ACT_REMOVE, 16'hffff, 16'hffff, 10'h3ff, 10'h3ff));
    drive_item(make_req(riq_pkg::ACT_INSERT, 16'h0000, 16'h0000, 10'd0, 10'd0));
    drive_item(make_req(riq_pkg::ACT_INSERT, 16'd1, 16'd100, 10'd5, 10'd7));
    drive_item(make_req(riq_pkg::ACT_INSERT, 16'd2, 16'd100, 10'd7, 10'd5));
    drive_item(make_req(riq_pkg::ACT_INSERT, 16'd3, 16'd100, 10'd5, 10'd5));
    drive_item(make_req(riq_pkg::ACT_INSERT, 16'd4, 16'd100, 10'd1, 10'd2));
    drive_item(make_req(riq_pkg::ACT_INSERT, 16'd5, 16'd100, 10'd5, 10'd9));
    drive_item(make_req(riq_pkg::ACT_INSERT, 16'hffff, 16'hffff, 10'h3ff, 10'h3ff));
    drive_item(make_req(riq_pkg::ACT_INSERT, 16'd6, 16'd99, 10'd0, 10'h3ff));
    repeat (10) drive_item(make_req(riq_pkg::ACT_REMOVE, 16'($urandom), 16'($urandom),
                                    10'($urandom), 10'($urandom)));
    idle_sender(1);

    // Random phases: each a course setting and an insert/remove balance
    for (int p = 0; p < PHASE_COUNT; p++) begin
      crs = (p == 0) ? 10'd0 : (p == 1) ? 10'h3ff : 10'($urandom);
      write_course(crs);
      no_gaps = (p == 3);
      if (no_gaps) hold_request = 1;
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        drive_item(random_req(crs, insert_pcts[p % 5]));
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if (!no_gaps && n != PHASE_ITEMS - 1) idle_sender($urandom_range(1, 12));
        end
      end
      idle_sender(1);
    end

    // Drain and let any stray beat show up
    while (table_model.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (table_model.mismatch_count == 0 && table_model.pending() == 0) begin
      $display("ranked_insert_queue: match");
    end else begin
      $display("ranked_insert_queue: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/riq_pkg.sv
hdl/riq_ctrl.sv
hdl/riq_datapath.sv
hdl/ranked_insert_queue.sv
hdl/riq_checker.sv
dv/ranked_insert_queue_tb.sv
